/* sv/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Depends on nothing; every macro clocks on a rising edge and reports with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset is high.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while the reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cdsfa_pkg.sv */
// Shared types and constants of the section frame aligner.
// Used by the front end, the back end and the top level; depends on nothing.
package cdsfa_pkg;

   localparam int DEF_SECTION_FRAMES = 98;
   localparam int DEF_PAYLOAD_WIDTH  = 64;
   localparam int DEF_COUNT_WIDTH    = 32;
   localparam int QUEUE_DEPTH        = 4;

   // Frame labels on the input channel.
   localparam logic [1:0] FT_SYNC0   = 2'd0;
   localparam logic [1:0] FT_SYNC1   = 2'd1;
   localparam logic [1:0] FT_SUBCODE = 2'd2;
   localparam logic [1:0] FT_NONE    = 2'd3;

   // Control part of one write command handed from the front end to the back end.
   typedef struct packed {
      logic zero_first;   // also write an all-zero frame into slot 0
      logic bump_first;
      logic bump_second;
      logic bump_subcode;
      logic bump_lost;
      logic complete;     // this write fills the last slot of the section
   } cdsfa_ctrl_type;

endpackage

/* sv/cd_section_frame_aligner_core.sv */
// Section frame aligner. Input channel req_*: one tagged frame per transaction
// (label sync0, sync1 or subcode, payload word, subcode byte); label 3 is dropped.
// Output channel rsp_*: one transaction per slot pair of a completed section,
// pairs 0 .. ceil(SECTION_FRAMES/2)-1, the last one flagged by rsp_last_pair, each
// carrying the five saturating statistics counters as they stand after the frame
// that completed the section. Both channels use valid/stall; a transaction
// completes on a rising edge with valid high and stall low.
// Flow: the front end classifies a frame in the cycle it is taken and writes a
// command into a QUEUE_DEPTH-entry queue. The back end retires one command per
// cycle into the slot stores while it is not draining a section. After the
// completing frame is retired, the back end passes through its read, load and
// send states for the first pair, and through load and send for each further
// pair once the previous one is taken. During the drain the back end retires
// nothing; frames keep coming in until the queue fills, then req_stall rises.
// Sustained input is held back by the drain of the slot stores.
// Receiver stall holds the offered pair and stops the drain.
// Reset (synchronous, active high) returns the aligner to expecting sync0, empties
// the queue and clears the counters; the slot stores are not cleared and need no
// clearing pass, since every slot is written before it is emitted.
module cd_section_frame_aligner_core #(
   parameter int SECTION_FRAMES = cdsfa_pkg::DEF_SECTION_FRAMES,
   parameter int PAYLOAD_WIDTH  = cdsfa_pkg::DEF_PAYLOAD_WIDTH,
   parameter int COUNT_WIDTH    = cdsfa_pkg::DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_frame_type,
   input  logic [63:0] req_payload_word,
   input  logic [7:0]  req_subcode_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_pair_index,
   output logic [63:0] rsp_even_payload,
   output logic [7:0]  rsp_even_subcode,
   output logic [63:0] rsp_odd_payload,
   output logic [7:0]  rsp_odd_subcode,
   output logic        rsp_last_pair,
   output logic [31:0] rsp_good_sections,
   output logic [31:0] rsp_lost_sections,
   output logic [31:0] rsp_missed_first_sync,
   output logic [31:0] rsp_missed_second_sync,
   output logic [31:0] rsp_missed_subcode_frames
);

   import cdsfa_pkg::*;

   localparam int SLOT_W  = $clog2(SECTION_FRAMES);
   localparam int CTRL_W  = $bits(cdsfa_ctrl_type);
   localparam int ENTRY_W = CTRL_W + SLOT_W + PAYLOAD_WIDTH + 8;

   // Front end to queue.
   logic                     push;
   logic                     q_full;
   logic [SLOT_W-1:0]        push_slot;
   logic [PAYLOAD_WIDTH-1:0] push_payload;
   logic [7:0]               push_sub;
   cdsfa_ctrl_type           push_ctrl;

   // Queue to back end.
   logic                     pop;
   logic                     q_not_empty;
   logic [ENTRY_W-1:0]       pop_data;
   logic [SLOT_W-1:0]        pop_slot;
   logic [PAYLOAD_WIDTH-1:0] pop_payload;
   logic [7:0]               pop_sub;
   cdsfa_ctrl_type           pop_ctrl;

   logic [COUNT_WIDTH-1:0]   good_cnt, lost_cnt, first_cnt, second_cnt, subc_cnt;

   cdsfa_front #(
      .SECTION_FRAMES (SECTION_FRAMES),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_type   (req_frame_type),
      .req_payload_word (req_payload_word),
      .req_subcode_byte (req_subcode_byte),
      .q_full           (q_full),
      .q_push           (push),
      .q_slot           (push_slot),
      .q_payload        (push_payload),
      .q_sub            (push_sub),
      .q_ctrl           (push_ctrl)
   );

   cdsfa_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctrl, push_slot, push_payload, push_sub}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   assign {pop_ctrl, pop_slot, pop_payload, pop_sub} = pop_data;

   cdsfa_back #(
      .SECTION_FRAMES (SECTION_FRAMES),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_not_empty),
      .q_pop            (pop),
      .q_slot           (pop_slot),
      .q_payload        (pop_payload),
      .q_sub            (pop_sub),
      .q_ctrl           (pop_ctrl),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pair_index   (rsp_pair_index),
      .rsp_even_payload (rsp_even_payload),
      .rsp_even_subcode (rsp_even_subcode),
      .rsp_odd_payload  (rsp_odd_payload),
      .rsp_odd_subcode  (rsp_odd_subcode),
      .rsp_last_pair    (rsp_last_pair),
      .good_cnt         (good_cnt),
      .lost_cnt         (lost_cnt),
      .miss_first_cnt   (first_cnt),
      .miss_second_cnt  (second_cnt),
      .miss_subcode_cnt (subc_cnt)
   );

   // Counters are kept at COUNT_WIDTH bits and shown zero-extended.
   assign rsp_good_sections         = 32'(good_cnt);
   assign rsp_lost_sections         = 32'(lost_cnt);
   assign rsp_missed_first_sync     = 32'(first_cnt);
   assign rsp_missed_second_sync    = 32'(second_cnt);
   assign rsp_missed_subcode_frames = 32'(subc_cnt);

endmodule

/* sv/cdsfa_queue.sv */
// Small first-in first-out command queue between the front end and the back end.
// Generic in width and depth; depends on nothing else.
module cdsfa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/cdsfa_front.sv */
// Front end of the section frame aligner: the three-state aligner that relabels
// frames and turns each labelled one into a slot write command. Depends on cdsfa_pkg.
module cdsfa_front #(
   parameter int SECTION_FRAMES = 98,
   parameter int PAYLOAD_WIDTH  = 64,
   localparam int SLOT_W        = $clog2(SECTION_FRAMES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_frame_type,
   input  logic [63:0]                req_payload_word,
   input  logic [7:0]                 req_subcode_byte,
   input  logic                       q_full,
   output logic                       q_push,
   output logic [SLOT_W-1:0]          q_slot,
   output logic [PAYLOAD_WIDTH-1:0]   q_payload,
   output logic [7:0]                 q_sub,
   output cdsfa_pkg::cdsfa_ctrl_type  q_ctrl
);

   import cdsfa_pkg::*;

   localparam logic [1:0] AL_SYNC0   = 2'd0;
   localparam logic [1:0] AL_SYNC1   = 2'd1;
   localparam logic [1:0] AL_SUBCODE = 2'd2;

   logic [1:0]        align_ff, align_in;
   logic [SLOT_W-1:0] fill_ff, fill_in;
   logic              accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      align_in  = align_ff;
      fill_in   = fill_ff;
      q_push    = 1'b0;
      q_slot    = '0;
      q_payload = req_payload_word[PAYLOAD_WIDTH-1:0];
      q_sub     = req_subcode_byte;
      q_ctrl    = '0;
      if (accept && req_frame_type != FT_NONE) begin
         q_push = 1'b1;
         unique case (align_ff)
            AL_SYNC0: begin
               if (req_frame_type == FT_SYNC1) begin
                  // Missing sync0: an all-zero frame is put in front.
                  q_slot            = SLOT_W'(1);
                  q_ctrl.zero_first = 1'b1;
                  q_ctrl.bump_first = 1'b1;
                  align_in          = AL_SUBCODE;
                  fill_in           = SLOT_W'(2);
               end else begin
                  q_slot            = '0;
                  q_ctrl.bump_first = (req_frame_type == FT_SUBCODE);
                  align_in          = AL_SYNC1;
                  fill_in           = SLOT_W'(1);
               end
            end
            AL_SYNC1: begin
               if (req_frame_type == FT_SYNC0) begin
                  q_slot             = '0;
                  q_ctrl.bump_second = 1'b1;
                  fill_in            = SLOT_W'(1);
               end else begin
                  q_slot             = SLOT_W'(1);
                  q_ctrl.bump_second = (req_frame_type == FT_SUBCODE);
                  align_in           = AL_SUBCODE;
                  fill_in            = SLOT_W'(2);
               end
            end
            AL_SUBCODE: begin
               if (req_frame_type == FT_SYNC0) begin
                  // Stray sync0 drops the partial section and starts over.
                  q_slot              = '0;
                  q_ctrl.bump_subcode = 1'b1;
                  q_ctrl.bump_lost    = 1'b1;
                  align_in            = AL_SYNC1;
                  fill_in             = SLOT_W'(1);
               end else begin
                  q_slot = fill_ff;
                  if (req_frame_type == FT_SYNC1) begin
                     q_ctrl.bump_subcode = 1'b1;
                     q_sub               = '0;
                  end
                  if (fill_ff == SLOT_W'(SECTION_FRAMES - 1)) begin
                     q_ctrl.complete = 1'b1;
                     align_in        = AL_SYNC0;
                     fill_in         = '0;
                  end else begin
                     fill_in = fill_ff + SLOT_W'(1);
                  end
               end
            end
            default: begin
               q_push   = 1'b0;
               align_in = AL_SYNC0;
               fill_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff <= AL_SYNC0;
         fill_ff  <= '0;
      end else begin
         align_ff <= align_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

/* sv/cdsfa_back.sv */
// Back end of the section frame aligner: slot stores in two banks (even and odd
// slots), statistics counters and the section drain. Depends on cdsfa_pkg.
module cdsfa_back #(
   parameter int SECTION_FRAMES = 98,
   parameter int PAYLOAD_WIDTH  = 64,
   parameter int COUNT_WIDTH    = 32,
   localparam int SLOT_W        = $clog2(SECTION_FRAMES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_pop,
   input  logic [SLOT_W-1:0]          q_slot,
   input  logic [PAYLOAD_WIDTH-1:0]   q_payload,
   input  logic [7:0]                 q_sub,
   input  cdsfa_pkg::cdsfa_ctrl_type  q_ctrl,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [5:0]                 rsp_pair_index,
   output logic [63:0]                rsp_even_payload,
   output logic [7:0]                 rsp_even_subcode,
   output logic [63:0]                rsp_odd_payload,
   output logic [7:0]                 rsp_odd_subcode,
   output logic                       rsp_last_pair,
   output logic [COUNT_WIDTH-1:0]     good_cnt,
   output logic [COUNT_WIDTH-1:0]     lost_cnt,
   output logic [COUNT_WIDTH-1:0]     miss_first_cnt,
   output logic [COUNT_WIDTH-1:0]     miss_second_cnt,
   output logic [COUNT_WIDTH-1:0]     miss_subcode_cnt
);

   import cdsfa_pkg::*;

   localparam int PAIRS  = (SECTION_FRAMES + 1) / 2;
   localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam bit ODD_N  = (SECTION_FRAMES % 2) == 1;

   localparam logic [1:0] BK_RUN  = 2'd0;
   localparam logic [1:0] BK_READ = 2'd1;
   localparam logic [1:0] BK_LOAD = 2'd2;
   localparam logic [1:0] BK_SEND = 2'd3;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                      input logic en);
      return (en && v != '1) ? v + COUNT_WIDTH'(1) : v;
   endfunction

   logic [PAYLOAD_WIDTH-1:0] even_pay_mem [PAIRS];
   logic [7:0]               even_sub_mem [PAIRS];
   logic [PAYLOAD_WIDTH-1:0] odd_pay_mem  [PAIRS];
   logic [7:0]               odd_sub_mem  [PAIRS];

   logic [PAYLOAD_WIDTH-1:0] rd_even_pay_ff, rd_odd_pay_ff;
   logic [7:0]               rd_even_sub_ff, rd_odd_sub_ff;

   logic [1:0]               state_ff, state_in;
   logic [PAIR_W-1:0]        k_ff, k_in;
   logic                     valid_ff, valid_in;
   logic [63:0]              even_pay_ff, odd_pay_ff;
   logic [7:0]               even_sub_ff, odd_sub_ff;
   logic                     load_out;
   logic                     last;
   logic                     odd_exists;
   logic [PAIR_W-1:0]        rd_addr;
   logic [PAIR_W-1:0]        wr_addr;

   logic [COUNT_WIDTH-1:0]   good_ff, lost_ff, first_ff, second_ff, subc_ff;

   assign last       = (k_ff == PAIR_W'(PAIRS - 1));
   assign odd_exists = !(ODD_N && last);
   assign q_pop      = (state_ff == BK_RUN) && q_valid;
   assign wr_addr    = PAIR_W'(q_slot >> 1);
   // While a pair is on offer, the next pair is already being read.
   assign rd_addr    = (state_ff == BK_SEND && !last) ? k_ff + PAIR_W'(1) : k_ff;
   assign load_out   = (state_ff == BK_LOAD);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (q_pop && q_ctrl.complete) begin
               state_in = BK_READ;
               k_in     = '0;
            end
         end
         BK_READ: state_in = BK_LOAD;
         BK_LOAD: begin
            state_in = BK_SEND;
            valid_in = 1'b1;
         end
         BK_SEND: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (last) begin
                  state_in = BK_RUN;
                  k_in     = '0;
               end else begin
                  state_in = BK_LOAD;
                  k_in     = k_ff + PAIR_W'(1);
               end
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_RUN;
         k_ff      <= '0;
         valid_ff  <= 1'b0;
         good_ff   <= '0;
         lost_ff   <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         subc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         valid_ff <= valid_in;
         if (q_pop) begin
            good_ff   <= sat_inc(good_ff, q_ctrl.complete);
            lost_ff   <= sat_inc(lost_ff, q_ctrl.bump_lost);
            first_ff  <= sat_inc(first_ff, q_ctrl.bump_first);
            second_ff <= sat_inc(second_ff, q_ctrl.bump_second);
            subc_ff   <= sat_inc(subc_ff, q_ctrl.bump_subcode);
         end
      end
   end

   // Slot stores: one write port per bank, registered read.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (q_ctrl.zero_first) begin
            even_pay_mem[PAIR_W'(0)] <= '0;
            even_sub_mem[PAIR_W'(0)] <= '0;
         end else if (!q_slot[0]) begin
            even_pay_mem[wr_addr] <= q_payload;
            even_sub_mem[wr_addr] <= q_sub;
         end
         if (q_slot[0]) begin
            odd_pay_mem[wr_addr] <= q_payload;
            odd_sub_mem[wr_addr] <= q_sub;
         end
      end
      rd_even_pay_ff <= even_pay_mem[rd_addr];
      rd_even_sub_ff <= even_sub_mem[rd_addr];
      rd_odd_pay_ff  <= odd_pay_mem[rd_addr];
      rd_odd_sub_ff  <= odd_sub_mem[rd_addr];
   end

   // Result register; slots 0 and 1 report a zero subcode byte.
   always_ff @(posedge clock) begin
      if (load_out) begin
         even_pay_ff <= 64'(rd_even_pay_ff);
         even_sub_ff <= (k_ff == '0) ? 8'd0 : rd_even_sub_ff;
         odd_pay_ff  <= odd_exists ? 64'(rd_odd_pay_ff) : 64'd0;
         odd_sub_ff  <= (k_ff == '0 || !odd_exists) ? 8'd0 : rd_odd_sub_ff;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pair_index   = 6'(k_ff);
   assign rsp_even_payload = even_pay_ff;
   assign rsp_even_subcode = even_sub_ff;
   assign rsp_odd_payload  = odd_pay_ff;
   assign rsp_odd_subcode  = odd_sub_ff;
   assign rsp_last_pair    = last;
   assign good_cnt         = good_ff;
   assign lost_cnt         = lost_ff;
   assign miss_first_cnt   = first_ff;
   assign miss_second_cnt  = second_ff;
   assign miss_subcode_cnt = subc_ff;

endmodule

/* sv/cdsfa_checker.sv */
// Port-level checks of the section frame aligner and the bind that attaches them.
// Depends on assert_macros.svh and on the top level cd_section_frame_aligner_core.
`include "assert_macros.svh"

module cdsfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_frame_type,
   input logic [63:0] req_payload_word,
   input logic [7:0]  req_subcode_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_pair_index,
   input logic [63:0] rsp_even_payload,
   input logic [7:0]  rsp_even_subcode,
   input logic [63:0] rsp_odd_payload,
   input logic [7:0]  rsp_odd_subcode,
   input logic        rsp_last_pair,
   input logic [31:0] rsp_good_sections,
   input logic [31:0] rsp_lost_sections,
   input logic [31:0] rsp_missed_first_sync,
   input logic [31:0] rsp_missed_second_sync,
   input logic [31:0] rsp_missed_subcode_frames
);

   // A stalled frame transaction keeps its valid and its fields.
   `CHK_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
             req_valid && $stable(req_frame_type) && $stable(req_payload_word) &&
             $stable(req_subcode_byte),
             "frame changed while stalled")

   // A stalled result transaction keeps its valid, its pair index and its two payloads.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
             rsp_valid && $stable(rsp_pair_index) && $stable(rsp_even_payload) &&
             $stable(rsp_odd_payload),
             "result changed while stalled")

   // Pairs of a section come out in order, one index after the other.
   `CHK_NEXT(a_pair_order, clock, reset, rsp_valid && !rsp_stall && !rsp_last_pair,
             rsp_pair_index == 6'($past(rsp_pair_index) + 6'd1),
             "pair index did not advance by one")

   // The first pair carries the two sync slots, whose subcode bytes read as zero.
   `CHK_IMPL(a_sync_sub_zero, clock, reset, rsp_valid && rsp_pair_index == 6'd0,
             rsp_even_subcode == 8'd0 && rsp_odd_subcode == 8'd0,
             "sync slot subcode byte not zero")

   // Statistics counters never go down outside reset.
   `CHK_IMPL(a_cnt_monotonic, clock, reset, !$past(reset),
             rsp_good_sections >= $past(rsp_good_sections) &&
             rsp_lost_sections >= $past(rsp_lost_sections) &&
             rsp_missed_first_sync >= $past(rsp_missed_first_sync) &&
             rsp_missed_second_sync >= $past(rsp_missed_second_sync) &&
             rsp_missed_subcode_frames >= $past(rsp_missed_subcode_frames),
             "statistics counter decreased")

endmodule

bind cd_section_frame_aligner_core cdsfa_checker u_cdsfa_checker (.*);

/* tb/cd_section_frame_aligner_core_test.sv */
// Self-checking testbench for cd_section_frame_aligner_core: a section predictor class
// tracks the aligner and its counters, plain tasks drive the frame channel and an
// initial block drives the result stall. Depends only on cdsfa_pkg and the core itself.
module cd_section_frame_aligner_core_test;
   import cdsfa_pkg::*;

   localparam int FRAMES = DEF_SECTION_FRAMES;
   localparam int PAIRS  = (FRAMES + 1) / 2;

   // Aligner states as the predictor tracks them.
   typedef enum logic [1:0] {EXPECT_SYNC0, EXPECT_SYNC1, EXPECT_SUBCODE} align_type;

   // One slot pair of a completed section, with the counters reported beside it.
   typedef struct {
      logic [5:0]  index;
      logic [63:0] even_payload;
      logic [7:0]  even_subcode;
      logic [63:0] odd_payload;
      logic [7:0]  odd_subcode;
      logic        last_pair;
      logic [31:0] good;
      logic [31:0] lost;
      logic [31:0] miss_first;
      logic [31:0] miss_second;
      logic [31:0] miss_subcode;
   } section_pair_type;

   // The predictor keeps its own copy of the aligner state, the slot stores and the
   // counters. Every accepted frame goes through take_frame; when a section fills,
   // all of its slot pairs are queued at once and the monitor checks them in order.
   class section_scoreboard_type;
      align_type        align;
      int unsigned      fill;
      logic [63:0]      payload_slots [FRAMES];
      logic [7:0]       subcode_slots [FRAMES];
      logic [31:0]      good, lost, miss_first, miss_second, miss_subcode;
      section_pair_type pending_pairs[$];
      int unsigned      sections_done, pairs_checked, bad_fields, stray_pairs, reported;

      function new();
         align = EXPECT_SYNC0;
         fill = 0;
         good = 0;
         lost = 0;
         miss_first = 0;
         miss_second = 0;
         miss_subcode = 0;
         sections_done = 0;
         pairs_checked = 0;
         bad_fields = 0;
         stray_pairs = 0;
         reported = 0;
      endfunction

      function logic [31:0] sat_inc(logic [31:0] c);
         return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
      endfunction

      function void put_slot(int unsigned slot, logic [63:0] payload, logic [7:0] sub);
         if (slot < FRAMES) begin
            payload_slots[slot] = payload;
            subcode_slots[slot] = sub;
         end
      endfunction

      function int queue_section();
         section_pair_type p;
         int unsigned e, d;
         for (int k = 0; k < PAIRS; k++) begin
            e = 2 * k;
            d = 2 * k + 1;
            p.index        = k[5:0];
            p.even_payload = payload_slots[e];
            p.even_subcode = (e < 2) ? 8'd0 : subcode_slots[e];
            p.odd_payload  = (d < FRAMES) ? payload_slots[d] : 64'd0;
            p.odd_subcode  = (d < 2 || d >= FRAMES) ? 8'd0 : subcode_slots[d];
            p.last_pair    = (k == PAIRS - 1);
            p.good         = good;
            p.lost         = lost;
            p.miss_first   = miss_first;
            p.miss_second  = miss_second;
            p.miss_subcode = miss_subcode;
            pending_pairs.push_back(p);
         end
         return PAIRS;
      endfunction

      // Returns the number of slot pairs this frame makes the block emit.
      function int take_frame(logic [1:0] label, logic [63:0] payload, logic [7:0] sub);
         logic [7:0] kept_sub;
         kept_sub = sub;
         if (label == FT_NONE) return 0;
         case (align)
            EXPECT_SYNC0: begin
               if (label == FT_SYNC1) begin
                  miss_first = sat_inc(miss_first);
                  put_slot(0, 64'd0, 8'd0);
                  put_slot(1, payload, sub);
                  fill = 2;
                  align = EXPECT_SUBCODE;
               end else begin
                  if (label == FT_SUBCODE) miss_first = sat_inc(miss_first);
                  put_slot(0, payload, sub);
                  fill = 1;
                  align = EXPECT_SYNC1;
               end
            end
            EXPECT_SYNC1: begin
               if (label == FT_SYNC0) begin
                  miss_second = sat_inc(miss_second);
                  put_slot(0, payload, sub);
                  fill = 1;
               end else begin
                  if (label == FT_SUBCODE) miss_second = sat_inc(miss_second);
                  put_slot(1, payload, sub);
                  fill = 2;
                  align = EXPECT_SUBCODE;
               end
            end
            default: begin
               if (label == FT_SYNC0) begin
                  miss_subcode = sat_inc(miss_subcode);
                  lost = sat_inc(lost);
                  put_slot(0, payload, sub);
                  fill = 1;
                  align = EXPECT_SYNC1;
               end else begin
                  if (label == FT_SYNC1) begin
                     miss_subcode = sat_inc(miss_subcode);
                     kept_sub = 8'd0;
                  end
                  put_slot(fill, payload, kept_sub);
                  fill++;
                  if (fill >= FRAMES) begin
                     good = sat_inc(good);
                     fill = 0;
                     align = EXPECT_SYNC0;
                     sections_done++;
                     return queue_section();
                  end
               end
            end
         endcase
         return 0;
      endfunction

      function void compare_field(string name, logic [5:0] k, logic [63:0] want,
                                  logic [63:0] got);
         if (want !== got) begin
            bad_fields++;
            if (reported < 10) begin
               reported++;
               $display("pair %0d field %s: expected %h, got %h", k, name, want, got);
            end
         end
      endfunction

      function void match_pair(section_pair_type got);
         section_pair_type want;
         if (pending_pairs.size() == 0) begin
            stray_pairs++;
            if (reported < 10) begin
               reported++;
               $display("unexpected slot pair %0d with nothing pending", got.index);
            end
            return;
         end
         want = pending_pairs.pop_front();
         pairs_checked++;
         compare_field("pair_index", want.index, 64'(want.index), 64'(got.index));
         compare_field("even_payload", want.index, want.even_payload, got.even_payload);
         compare_field("even_subcode", want.index, 64'(want.even_subcode),
                       64'(got.even_subcode));
         compare_field("odd_payload", want.index, want.odd_payload, got.odd_payload);
         compare_field("odd_subcode", want.index, 64'(want.odd_subcode),
                       64'(got.odd_subcode));
         compare_field("last_pair", want.index, 64'(want.last_pair), 64'(got.last_pair));
         compare_field("good_sections", want.index, 64'(want.good), 64'(got.good));
         compare_field("lost_sections", want.index, 64'(want.lost), 64'(got.lost));
         compare_field("missed_first_sync", want.index, 64'(want.miss_first),
                       64'(got.miss_first));
         compare_field("missed_second_sync", want.index, 64'(want.miss_second),
                       64'(got.miss_second));
         compare_field("missed_subcode_frames", want.index, 64'(want.miss_subcode),
                       64'(got.miss_subcode));
      endfunction

      function int unsigned failures();
         return bad_fields + stray_pairs + pending_pairs.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_frame_type;
   logic [63:0] req_payload_word;
   logic [7:0]  req_subcode_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_pair_index;
   logic [63:0] rsp_even_payload;
   logic [7:0]  rsp_even_subcode;
   logic [63:0] rsp_odd_payload;
   logic [7:0]  rsp_odd_subcode;
   logic        rsp_last_pair;
   logic [31:0] rsp_good_sections;
   logic [31:0] rsp_lost_sections;
   logic [31:0] rsp_missed_first_sync;
   logic [31:0] rsp_missed_second_sync;
   logic [31:0] rsp_missed_subcode_frames;

   section_scoreboard_type book = new();

   // Handshake between the stimulus and the receiver: the stimulus asks once for a
   // long receiver hold-off, the receiver counts it out on its own and marks it done.
   bit hold_off_wanted = 0;
   bit hold_off_done = 0;

   // Sender pacing and bookkeeping.
   int burst_left = 1;
   int fresh_pairs;
   int unsigned frames_sent = 0;
   int unsigned labels_dropped = 0;

   cd_section_frame_aligner_core u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_frame_type            (req_frame_type),
      .req_payload_word          (req_payload_word),
      .req_subcode_byte          (req_subcode_byte),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_pair_index            (rsp_pair_index),
      .rsp_even_payload          (rsp_even_payload),
      .rsp_even_subcode          (rsp_even_subcode),
      .rsp_odd_payload           (rsp_odd_payload),
      .rsp_odd_subcode           (rsp_odd_subcode),
      .rsp_last_pair             (rsp_last_pair),
      .rsp_good_sections         (rsp_good_sections),
      .rsp_lost_sections         (rsp_lost_sections),
      .rsp_missed_first_sync     (rsp_missed_first_sync),
      .rsp_missed_second_sync    (rsp_missed_second_sync),
      .rsp_missed_subcode_frames (rsp_missed_subcode_frames)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one frame and holds it until the core takes it. The transaction is
   // credited to the predictor at the accepting edge, then the burst pacing decides
   // whether the sender idles before the next frame. Valid is only lowered ahead of a
   // wait on the clock, so it is never lowered and raised in the same step.
   task automatic offer(input logic [1:0] label, input logic [63:0] payload,
                        input logic [7:0] sub);
      int gap;
      req_valid        <= 1'b1;
      req_frame_type   <= label;
      req_payload_word <= payload;
      req_subcode_byte <= sub;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fresh_pairs = book.take_frame(label, payload, sub);
      if (label == FT_NONE) labels_dropped++;
      else frames_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         // Some bursts run straight into the next one with no gap at all.
         if ($urandom_range(0, 9) < 7) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Sender stands idle until every predicted slot pair has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending_pairs.size() != 0) @(posedge clock);
   endtask

   // Random payload with the all-zero and all-one words mixed in now and then.
   function automatic logic [63:0] pick_payload();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 64'd0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   // Stimulus. After reset, a short directed run walks every relabelling and resync rule
   // but a subcode in place of sync0, and the ignored label in each of the three aligner
   // states. After that come random sections: mostly well-formed sync0, sync1 and
   // subcode runs with random content, with a small and varying rate of corrupted
   // labels so that stray syncs, lost sections and the ignored label keep turning up.
   initial begin : stimulus
      logic [1:0] label;
      int unsigned plain_frames;
      int noise_pct;
      int sections_seen;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_frame_type   <= FT_SYNC0;
      req_payload_word <= 64'd0;
      req_subcode_byte <= 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Right after reset the aligner expects sync0.
      offer(FT_NONE, '1, 8'hFF);                          // ignored while expecting sync0
      offer(FT_SYNC1, '1, 8'hFF);                         // sync1 first: zero sync0 put in front
      offer(FT_SUBCODE, 64'd0, 8'h00);
      offer(FT_SUBCODE, 64'h8000_0000_0000_0001, 8'h80);
      offer(FT_NONE, 64'd0, 8'h00);                       // ignored while expecting subcode
      offer(FT_SYNC1, 64'h5555_5555_5555_5555, 8'h55);    // stray sync1 becomes a subcode
      offer(FT_SYNC0, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA);    // stray sync0 throws the section away
      offer(FT_NONE, 64'h0123_4567_89AB_CDEF, 8'h01);     // ignored while expecting sync1
      offer(FT_SYNC0, '1, 8'hFE);                         // second sync0 restarts the section
      offer(FT_SUBCODE, 64'hFEDC_BA98_7654_3210, 8'h7F);  // subcode taken as sync1
      offer(FT_SUBCODE, '1, 8'hFF);
      offer(FT_SYNC0, 64'd0, 8'h00);                      // another lost section
      offer(FT_SYNC1, 64'h0F0F_0F0F_0F0F_0F0F, 8'hF0);    // clean sync1
      offer(FT_SUBCODE, 64'hF0F0_F0F0_F0F0_F0F0, 8'h0F);
      offer(FT_SUBCODE, 64'd1, 8'h01);

      // Random part. The directed run left a section open, so the first random
      // section completes it; it runs without corrupted labels so that it surely
      // completes and brings on the long receiver hold-off.
      plain_frames = 0;
      sections_seen = 0;
      noise_pct = 0;
      while (plain_frames < 255) begin
         case (book.align)
            EXPECT_SYNC0: label = FT_SYNC0;
            EXPECT_SYNC1: label = FT_SYNC1;
            default:      label = FT_SUBCODE;
         endcase
         if ($urandom_range(0, 99) < noise_pct) label = 2'($urandom_range(0, 3));
         offer(label, pick_payload(), 8'($urandom_range(0, 255)));
         if (label != FT_NONE) plain_frames++;
         if (fresh_pairs > 0) begin
            sections_seen++;
            // First full section: the receiver holds off for a long time while frames
            // keep coming, so the core's queue fills and it stalls its input.
            // Second one: the sender waits for the whole section to drain.
            if (sections_seen == 1) hold_off_wanted = 1'b1;
            else if (sections_seen == 2) wait_for_drain();
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: noise_pct = 1;
               6, 7:             noise_pct = 4;
               default:          noise_pct = 0;
            endcase
         end
      end

      // Drain: nothing left to send, wait for the last section, then give the core
      // time to show any result it should not produce.
      wait_for_drain();
      repeat (200) @(posedge clock);

      $display("Sent %0d labelled frames and %0d ignored ones; %0d sections completed.",
               frames_sent, labels_dropped, book.sections_done);
      $display("Checked %0d slot pairs: %0d field mismatches, %0d unexpected pairs.",
               book.pairs_checked, book.bad_fields, book.stray_pairs);
      if (book.failures() == 0) begin
         $display("cd_section_frame_aligner_core_test: clean");
      end else begin
         $display("cd_section_frame_aligner_core_test: errors");
      end
      $finish;
   end

   // Receiver. It switches between stall patterns of its own after random spans:
   // no stall, coin-flip stalls, stalls two thirds of the time, and regular stall runs.
   // Once the stimulus asks for it, it holds off in one long stretch.
   initial begin : receiver
      int mode, span;
      rsp_stall <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 80);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            if (hold_off_wanted && !hold_off_done) begin
               rsp_stall <= 1'b1;
               repeat (500) @(posedge clock);
               hold_off_done = 1'b1;
            end
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               2:       rsp_stall <= (i % 3 != 0);
               default: rsp_stall <= (i % 16 < 6);
            endcase
         end
      end
   end

   // Monitor: a slot pair moves when valid is high and stall is low at the edge.
   // Both are sampled before this edge's updates land, so the check is race-free.
   always @(posedge clock) begin : rsp_monitor
      section_pair_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.index        = rsp_pair_index;
         got.even_payload = rsp_even_payload;
         got.even_subcode = rsp_even_subcode;
         got.odd_payload  = rsp_odd_payload;
         got.odd_subcode  = rsp_odd_subcode;
         got.last_pair    = rsp_last_pair;
         got.good         = rsp_good_sections;
         got.lost         = rsp_lost_sections;
         got.miss_first   = rsp_missed_first_sync;
         got.miss_second  = rsp_missed_second_sync;
         got.miss_subcode = rsp_missed_subcode_frames;
         book.match_pair(got);
      end
   end

   // Watchdog, well beyond the slowest legal run.
   initial begin : watchdog
      #400000;
      $display("cd_section_frame_aligner_core_test: errors");
      $finish;
   end

endmodule

/* cd_section_frame_aligner_core.f */
+incdir+sv
sv/cdsfa_pkg.sv
sv/cdsfa_queue.sv
sv/cdsfa_front.sv
sv/cdsfa_back.sv
sv/cd_section_frame_aligner_core.sv
sv/cdsfa_checker.sv
tb/cd_section_frame_aligner_core_test.sv
